[rtl/core/dcd_pkg.sv]
`timescale 1ns / 1ps
// Shared types, codes and the peripheral routing table of the DMA channel dispatcher.
// Depends on nothing; used by the dispatcher top level.
package dcd_pkg;

    localparam int NUM_CHANNELS    = 4;
    localparam int NUM_PERIPHERALS = 20;
    localparam int CH_W            = 2;
    localparam int PER_W           = 5;
    localparam int TAG_W           = 8;
    localparam int SRC_W           = 3;
    localparam int QENT_W          = PER_W + TAG_W;

    localparam logic [SRC_W-1:0] SRC_NONE = 3'd7;

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_DONE  = 2'd1,
        CMD_ABORT = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        OC_STARTED = 3'd0,
        OC_QUEUED  = 3'd1,
        OC_BADPER  = 3'd2,
        OC_FULL    = 3'd3,
        OC_IDLE    = 3'd4,
        OC_ABORTED = 3'd5,
        OC_MISS    = 3'd6
    } outcome_t;

    localparam logic [2:0] PER_COUNT [NUM_PERIPHERALS] = '{
        3'd4, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd2, 3'd2, 3'd3, 3'd1,
        3'd1, 3'd2, 3'd2, 3'd2, 3'd2, 3'd3, 3'd1, 3'd1, 3'd1, 3'd1
    };

    localparam logic [CH_W-1:0] PER_ORDER [NUM_PERIPHERALS][NUM_CHANNELS] = '{
        '{2'd0, 2'd1, 2'd2, 2'd3},
        '{2'd0, 2'd0, 2'd0, 2'd0},
        '{2'd1, 2'd0, 2'd0, 2'd0},
        '{2'd0, 2'd0, 2'd0, 2'd0},
        '{2'd1, 2'd0, 2'd0, 2'd0},
        '{2'd3, 2'd0, 2'd0, 2'd0},
        '{2'd0, 2'd2, 2'd0, 2'd0},
        '{2'd1, 2'd2, 2'd0, 2'd0},
        '{2'd3, 2'd2, 2'd1, 2'd0},
        '{2'd1, 2'd0, 2'd0, 2'd0},
        '{2'd3, 2'd0, 2'd0, 2'd0},
        '{2'd0, 2'd2, 2'd0, 2'd0},
        '{2'd1, 2'd3, 2'd0, 2'd0},
        '{2'd2, 2'd3, 2'd0, 2'd0},
        '{2'd2, 2'd3, 2'd0, 2'd0},
        '{2'd0, 2'd2, 2'd3, 2'd0},
        '{2'd0, 2'd0, 2'd0, 2'd0},
        '{2'd1, 2'd0, 2'd0, 2'd0},
        '{2'd2, 2'd0, 2'd0, 2'd0},
        '{2'd3, 2'd0, 2'd0, 2'd0}
    };

    localparam logic [SRC_W-1:0] PER_SOURCE [NUM_PERIPHERALS][NUM_CHANNELS] = '{
        '{3'd0, 3'd0, 3'd0, 3'd0},
        '{3'd0, 3'd7, 3'd7, 3'd7},
        '{3'd7, 3'd0, 3'd7, 3'd7},
        '{3'd1, 3'd7, 3'd7, 3'd7},
        '{3'd7, 3'd1, 3'd7, 3'd7},
        '{3'd7, 3'd7, 3'd7, 3'd0},
        '{3'd5, 3'd7, 3'd0, 3'd7},
        '{3'd7, 3'd2, 3'd1, 3'd7},
        '{3'd2, 3'd6, 3'd2, 3'd1},
        '{3'd7, 3'd3, 3'd7, 3'd7},
        '{3'd7, 3'd7, 3'd7, 3'd2},
        '{3'd6, 3'd7, 3'd5, 3'd7},
        '{3'd7, 3'd5, 3'd7, 3'd6},
        '{3'd7, 3'd7, 3'd6, 3'd5},
        '{3'd7, 3'd7, 3'd6, 3'd5},
        '{3'd3, 3'd7, 3'd3, 3'd3},
        '{3'd4, 3'd7, 3'd7, 3'd7},
        '{3'd7, 3'd4, 3'd7, 3'd7},
        '{3'd7, 3'd7, 3'd4, 3'd7},
        '{3'd7, 3'd7, 3'd7, 3'd4}
    };

    // Hardware source select of a valid peripheral on a channel; software and
    // unrouted pairs give zero.
    function automatic logic [SRC_W-1:0] src_sel(input logic [PER_W-1:0] per,
                                                 input logic [CH_W-1:0] ch);
        logic [SRC_W-1:0] src;
        src = PER_SOURCE[per][ch];
        if (per == '0 || src == SRC_NONE)
        begin
            src = '0;
        end
        return src;
    endfunction

endpackage

[rtl/core/dma_channel_dispatcher.sv]
`timescale 1ns / 1ps
// Top level of the DMA channel dispatcher: sequencer, channel state and queues.
// Depends on dcd_pkg and dcd_ram.
//
// Requests enter on the in_valid/in_ready channel: start (cmd, peripheral, tag),
// done (channel) or abort (channel, tag). Every request gives exactly one result
// on the out_valid/out_ready channel. The block works on one request at a time
// and drops in_ready while it does. A start walks the peripheral's channel
// preference list one entry per cycle. A done or abort touches the per-channel
// queue held in one RAM with a registered read: a done reads the head and then
// moves each later entry down by one with a read and a write; an abort reads and
// compares entries until the tag matches, then moves the later ones down alike.
// Rejected ids, requests on an empty queue and the unused command go straight to
// the result. in_ready returns in the cycle after each result is loaded.
// The result sits in an output register,
// so a new request is taken while an earlier result still waits; a request that
// finishes while the output register is full holds until the receiver takes it.
// Reset marks all channels idle and all queues empty; queue contents need no
// clearing.
module dma_channel_dispatcher #(
    parameter int QUEUE_DEPTH = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  cmd,
    input  logic [dcd_pkg::PER_W-1:0]   peripheral,
    input  logic [dcd_pkg::TAG_W-1:0]   tag,
    input  logic [dcd_pkg::CH_W-1:0]    channel,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [2:0]                  outcome,
    output logic [dcd_pkg::CH_W-1:0]    out_channel,
    output logic [dcd_pkg::TAG_W-1:0]   out_tag,
    output logic [dcd_pkg::SRC_W-1:0]   source_select,
    output logic                        software_request
);
    import dcd_pkg::*;

    localparam int QDEPTH = NUM_CHANNELS * QUEUE_DEPTH;
    localparam int AW     = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CW     = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_SCAN  = 10'b00_0000_0010,
        S_HREAD = 10'b00_0000_0100,
        S_HCAP  = 10'b00_0000_1000,
        S_SH_RD = 10'b00_0001_0000,
        S_SH_WR = 10'b00_0010_0000,
        S_ARD   = 10'b00_0100_0000,
        S_ACMP  = 10'b00_1000_0000,
        S_FIN   = 10'b01_0000_0000,
        S_SPARE = 10'b10_0000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [NUM_CHANNELS-1:0] busy_reg, busy_next;
    logic [CW-1:0]           qcount_reg [NUM_CHANNELS];
    logic [CW-1:0]           qcount_next [NUM_CHANNELS];

    logic [1:0]        cmd_reg, cmd_next;
    logic [PER_W-1:0]  per_reg, per_next;
    logic [TAG_W-1:0]  tag_reg, tag_next;
    logic [CH_W-1:0]   ch_reg, ch_next;
    logic [1:0]        scan_reg, scan_next;
    logic [CW-1:0]     idx_reg, idx_next;
    logic [QENT_W-1:0] head_reg, head_next;

    logic [2:0]       res_oc_reg, res_oc_next;
    logic [CH_W-1:0]  res_ch_reg, res_ch_next;
    logic [TAG_W-1:0] res_tag_reg, res_tag_next;
    logic [SRC_W-1:0] res_src_reg, res_src_next;
    logic             res_sw_reg, res_sw_next;

    logic             out_valid_reg, out_valid_next;
    logic [2:0]       out_oc_reg, out_oc_next;
    logic [CH_W-1:0]  out_ch_reg, out_ch_next;
    logic [TAG_W-1:0] out_tag_reg, out_tag_next;
    logic [SRC_W-1:0] out_src_reg, out_src_next;
    logic             out_sw_reg, out_sw_next;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    logic [QENT_W-1:0] ram_wdata, ram_rdata;
    logic [CH_W-1:0]   wr_ch;
    logic [CW-1:0]     wr_idx;

    logic [CH_W-1:0]  scan_ch, first_ch;
    logic [CW-1:0]    idx_inc;
    logic [CW-1:0]    cur_count;
    logic             accept;

    dcd_ram #(
        .WIDTH (QENT_W),
        .DEPTH (QDEPTH)
    ) u_queue_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign accept    = in_valid && in_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign idx_inc   = idx_reg + CW'(1);
    assign cur_count = qcount_reg[ch_reg];
    assign scan_ch   = PER_ORDER[per_reg][scan_reg];
    assign first_ch  = PER_ORDER[per_reg][0];
    assign ram_raddr = AW'(int'(ch_reg) * QUEUE_DEPTH + int'(idx_reg));
    assign ram_waddr = AW'(int'(wr_ch) * QUEUE_DEPTH + int'(wr_idx));

    always_comb
    begin
        state_next   = state_reg;
        busy_next    = busy_reg;
        qcount_next  = qcount_reg;
        cmd_next     = cmd_reg;
        per_next     = per_reg;
        tag_next     = tag_reg;
        ch_next      = ch_reg;
        scan_next    = scan_reg;
        idx_next     = idx_reg;
        head_next    = head_reg;
        res_oc_next  = res_oc_reg;
        res_ch_next  = res_ch_reg;
        res_tag_next = res_tag_reg;
        res_src_next = res_src_reg;
        res_sw_next  = res_sw_reg;
        ram_we       = 1'b0;
        ram_wdata    = ram_rdata;
        wr_ch        = ch_reg;
        wr_idx       = idx_reg - CW'(1);

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next     = cmd;
                    per_next     = peripheral;
                    tag_next     = tag;
                    ch_next      = channel;
                    scan_next    = '0;
                    idx_next     = '0;
                    res_ch_next  = channel;
                    res_tag_next = '0;
                    res_src_next = '0;
                    res_sw_next  = 1'b0;
                    res_oc_next  = OC_MISS;
                    state_next   = S_FIN;
                    case (cmd)
                        CMD_START:
                        begin
                            if (int'(peripheral) >= NUM_PERIPHERALS)
                            begin
                                res_oc_next = OC_BADPER;
                                res_ch_next = '0;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        CMD_DONE:
                        begin
                            busy_next[channel] = 1'b0;
                            if (qcount_reg[channel] == '0)
                            begin
                                res_oc_next = OC_IDLE;
                            end
                            else
                            begin
                                state_next = S_HREAD;
                            end
                        end
                        CMD_ABORT:
                        begin
                            if (qcount_reg[channel] != '0)
                            begin
                                state_next = S_ARD;
                            end
                        end
                        default:
                        begin
                            res_oc_next = OC_MISS;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (!busy_reg[scan_ch])
                begin
                    busy_next[scan_ch] = 1'b1;
                    res_oc_next  = OC_STARTED;
                    res_ch_next  = scan_ch;
                    res_tag_next = tag_reg;
                    res_src_next = src_sel(per_reg, scan_ch);
                    res_sw_next  = (per_reg == '0);
                    state_next   = S_FIN;
                end
                else if ({1'b0, scan_reg} + 3'd1 == PER_COUNT[per_reg])
                begin
                    res_ch_next = first_ch;
                    state_next  = S_FIN;
                    if (qcount_reg[first_ch] == CW'(QUEUE_DEPTH))
                    begin
                        res_oc_next = OC_FULL;
                    end
                    else
                    begin
                        ram_we    = 1'b1;
                        wr_ch     = first_ch;
                        wr_idx    = qcount_reg[first_ch];
                        ram_wdata = {per_reg, tag_reg};
                        qcount_next[first_ch] = qcount_reg[first_ch] + CW'(1);
                        res_oc_next  = OC_QUEUED;
                        res_tag_next = tag_reg;
                    end
                end
                else
                begin
                    scan_next = scan_reg + 2'd1;
                end
            end
            S_HREAD:
            begin
                state_next = S_HCAP;
            end
            S_HCAP, S_SH_WR, S_ACMP:
            begin
                if (state_reg == S_HCAP)
                begin
                    head_next = ram_rdata;
                end
                if (state_reg == S_SH_WR)
                begin
                    ram_we = 1'b1;
                end
                if (state_reg == S_ACMP && ram_rdata[TAG_W-1:0] != tag_reg)
                begin
                    if (idx_inc < cur_count)
                    begin
                        idx_next   = idx_inc;
                        state_next = S_ARD;
                    end
                    else
                    begin
                        res_oc_next = OC_MISS;
                        state_next  = S_FIN;
                    end
                end
                else if (idx_inc < cur_count)
                begin
                    idx_next   = idx_inc;
                    state_next = S_SH_RD;
                end
                else
                begin
                    qcount_next[ch_reg] = cur_count - CW'(1);
                    state_next = S_FIN;
                    if (cmd_reg == CMD_DONE)
                    begin
                        if (state_reg == S_HCAP)
                        begin
                            busy_next[ch_reg] = 1'b1;
                            res_oc_next  = OC_STARTED;
                            res_tag_next = ram_rdata[TAG_W-1:0];
                            res_src_next = src_sel(ram_rdata[QENT_W-1:TAG_W], ch_reg);
                            res_sw_next  = (ram_rdata[QENT_W-1:TAG_W] == '0);
                        end
                        else
                        begin
                            busy_next[ch_reg] = 1'b1;
                            res_oc_next  = OC_STARTED;
                            res_tag_next = head_reg[TAG_W-1:0];
                            res_src_next = src_sel(head_reg[QENT_W-1:TAG_W], ch_reg);
                            res_sw_next  = (head_reg[QENT_W-1:TAG_W] == '0);
                        end
                    end
                    else
                    begin
                        res_oc_next  = OC_ABORTED;
                        res_tag_next = tag_reg;
                    end
                end
            end
            S_SH_RD:
            begin
                state_next = S_SH_WR;
            end
            S_ARD:
            begin
                state_next = S_ACMP;
            end
            S_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        out_oc_next    = out_oc_reg;
        out_ch_next    = out_ch_reg;
        out_tag_next   = out_tag_reg;
        out_src_next   = out_src_reg;
        out_sw_next    = out_sw_reg;
        if (state_reg == S_FIN && (!out_valid_reg || out_ready))
        begin
            out_valid_next = 1'b1;
            out_oc_next    = res_oc_reg;
            out_ch_next    = res_ch_reg;
            out_tag_next   = res_tag_reg;
            out_src_next   = res_src_reg;
            out_sw_next    = res_sw_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            busy_reg      <= '0;
            qcount_reg    <= '{default: '0};
            scan_reg      <= '0;
            idx_reg       <= '0;
            cmd_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            busy_reg      <= busy_next;
            qcount_reg    <= qcount_next;
            scan_reg      <= scan_next;
            idx_reg       <= idx_next;
            cmd_reg       <= cmd_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        per_reg     <= per_next;
        tag_reg     <= tag_next;
        ch_reg      <= ch_next;
        head_reg    <= head_next;
        res_oc_reg  <= res_oc_next;
        res_ch_reg  <= res_ch_next;
        res_tag_reg <= res_tag_next;
        res_src_reg <= res_src_next;
        res_sw_reg  <= res_sw_next;
        out_oc_reg  <= out_oc_next;
        out_ch_reg  <= out_ch_next;
        out_tag_reg <= out_tag_next;
        out_src_reg <= out_src_next;
        out_sw_reg  <= out_sw_next;
    end

    assign out_valid        = out_valid_reg;
    assign outcome          = out_oc_reg;
    assign out_channel      = out_ch_reg;
    assign out_tag          = out_tag_reg;
    assign source_select    = out_src_reg;
    assign software_request = out_sw_reg;

endmodule

[rtl/core/dcd_ram.sv]
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module dcd_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[tb/sv/dispatch_tb_pkg.sv]
`timescale 1ns / 1ps
// Request tracker for the DMA channel dispatcher testbench: predicts each result and checks it.
// Depends on dcd_pkg for field widths, codes and the peripheral routing table.
package dispatch_tb_pkg;

    import dcd_pkg::*;

    localparam int QDEPTH = 8;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        outcome_t         oc;
        logic [CH_W-1:0]  ch;
        logic [TAG_W-1:0] tg;
        logic [SRC_W-1:0] src;
        logic             sw;
    } dispatch_result_t;

    typedef struct packed {
        logic [PER_W-1:0] per;
        logic [TAG_W-1:0] tg;
    } queued_req_t;

    class dispatch_tracker;
        bit               busy [NUM_CHANNELS];
        queued_req_t      slots [NUM_CHANNELS][QDEPTH];
        int               depth [NUM_CHANNELS];
        dispatch_result_t pending_results [$];
        int               errors;
        int               checked;
        int               outcome_seen [7];

        function new();
            for (int c = 0; c < NUM_CHANNELS; c++)
            begin
                busy[c] = 1'b0;
                depth[c] = 0;
            end
            for (int k = 0; k < 7; k++)
            begin
                outcome_seen[k] = 0;
            end
            errors = 0;
            checked = 0;
        endfunction

        function dispatch_result_t launch(int ch, logic [PER_W-1:0] per,
                                          logic [TAG_W-1:0] tg);
            dispatch_result_t r;
            logic [SRC_W-1:0] s;
            r = '0;
            busy[ch] = 1'b1;
            r.oc = OC_STARTED;
            r.ch = CH_W'(ch);
            r.tg = tg;
            r.sw = (per == '0);
            if (per != '0)
            begin
                s = PER_SOURCE[per][ch];
                if (s != SRC_NONE)
                begin
                    r.src = s;
                end
            end
            return r;
        endfunction

        function dispatch_result_t predict_outcome(logic [1:0] c, logic [PER_W-1:0] per,
                                                   logic [TAG_W-1:0] tg,
                                                   logic [CH_W-1:0] ch);
            dispatch_result_t r;
            queued_req_t      head;
            int               first;
            int               pos;
            r = '0;
            r.oc = OC_MISS;
            r.ch = ch;
            case (c)
                CMD_START:
                begin
                    if (per >= NUM_PERIPHERALS)
                    begin
                        r.oc = OC_BADPER;
                        r.ch = '0;
                        return r;
                    end
                    for (int i = 0; i < PER_COUNT[per]; i++)
                    begin
                        if (!busy[PER_ORDER[per][i]])
                        begin
                            return launch(int'(PER_ORDER[per][i]), per, tg);
                        end
                    end
                    first = int'(PER_ORDER[per][0]);
                    r.ch = CH_W'(first);
                    if (depth[first] >= QDEPTH)
                    begin
                        r.oc = OC_FULL;
                        return r;
                    end
                    slots[first][depth[first]] = '{per: per, tg: tg};
                    depth[first]++;
                    r.oc = OC_QUEUED;
                    r.tg = tg;
                end
                CMD_DONE:
                begin
                    busy[ch] = 1'b0;
                    if (depth[ch] == 0)
                    begin
                        r.oc = OC_IDLE;
                        return r;
                    end
                    head = slots[ch][0];
                    for (int i = 1; i < depth[ch]; i++)
                    begin
                        slots[ch][i-1] = slots[ch][i];
                    end
                    depth[ch]--;
                    return launch(int'(ch), head.per, head.tg);
                end
                CMD_ABORT:
                begin
                    pos = -1;
                    for (int i = 0; i < depth[ch]; i++)
                    begin
                        if (pos < 0 && slots[ch][i].tg == tg)
                        begin
                            pos = i;
                        end
                    end
                    if (pos >= 0)
                    begin
                        for (int k = pos + 1; k < depth[ch]; k++)
                        begin
                            slots[ch][k-1] = slots[ch][k];
                        end
                        depth[ch]--;
                        r.oc = OC_ABORTED;
                        r.tg = tg;
                    end
                end
                default:
                begin
                    r.oc = OC_MISS;
                end
            endcase
            return r;
        endfunction

        function void note_request(logic [1:0] c, logic [PER_W-1:0] per,
                                   logic [TAG_W-1:0] tg, logic [CH_W-1:0] ch);
            pending_results.push_back(predict_outcome(c, per, tg, ch));
        endfunction

        function bit pick_queued_tag(inout logic [CH_W-1:0] ch, inout logic [TAG_W-1:0] tg);
            int start;
            int c;
            start = $urandom_range(NUM_CHANNELS - 1);
            for (int n = 0; n < NUM_CHANNELS; n++)
            begin
                c = (start + n) % NUM_CHANNELS;
                if (depth[c] != 0)
                begin
                    ch = CH_W'(c);
                    tg = slots[c][$urandom_range(depth[c] - 1)].tg;
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        function void compare_field(string label, int want, int got);
            if (want != got)
            begin
                $display("%0t: %s mismatch: expected %0d, actual %0d", $time, label, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [2:0] oc, logic [CH_W-1:0] ch, logic [TAG_W-1:0] tg,
                                   logic [SRC_W-1:0] src, logic sw);
            dispatch_result_t want;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, actual outcome %0d channel %0d",
                         $time, oc, ch);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            checked++;
            if (oc < 7)
            begin
                outcome_seen[oc]++;
            end
            compare_field("outcome", int'(want.oc), int'(oc));
            compare_field("out_channel", int'(want.ch), int'(ch));
            compare_field("out_tag", int'(want.tg), int'(tg));
            compare_field("source_select", int'(want.src), int'(src));
            compare_field("software_request", int'(want.sw), int'(sw));
        endfunction
    endclass

endpackage

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// Top-level testbench of the DMA channel dispatcher: clock, reset, request driver and
// result monitor. Depends on dcd_pkg, dispatch_tb_pkg and the dispatcher RTL.
module testbench;

    import dcd_pkg::*;
    import dispatch_tb_pkg::*;

    localparam int ITEMS        = 1300;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 40;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [1:0]          cmd = '0;
    logic [PER_W-1:0]    peripheral = '0;
    logic [TAG_W-1:0]    tag = '0;
    logic [CH_W-1:0]     channel = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [2:0]          outcome;
    logic [CH_W-1:0]     out_channel;
    logic [TAG_W-1:0]    out_tag;
    logic [SRC_W-1:0]    source_select;
    logic                software_request;

    int                  send_idle_pct = 19;
    int                  recv_idle_pct = 49;
    int                  cycles = 0;
    int                  sent = 0;
    bit                  fill_mode;
    dispatch_tracker     tracker;

    dma_channel_dispatcher #(
        .QUEUE_DEPTH(QDEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .cmd(cmd),
        .peripheral(peripheral),
        .tag(tag),
        .channel(channel),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .outcome(outcome),
        .out_channel(out_channel),
        .out_tag(out_tag),
        .source_select(source_select),
        .software_request(software_request)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("testbench failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            tracker.check_result(outcome, out_channel, out_tag, source_select,
                                 software_request);
        end
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_req(input logic [1:0] c, input logic [PER_W-1:0] p,
                            input logic [TAG_W-1:0] t, input logic [CH_W-1:0] ch);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd <= c;
        peripheral <= p;
        tag <= t;
        channel <= ch;
        do @(posedge clk); while (!in_ready);
        tracker.note_request(c, p, t, ch);
        sent++;
    endtask

    task automatic send_random();
        int               pick;
        logic [1:0]       c;
        logic [PER_W-1:0] p;
        logic [TAG_W-1:0] t;
        logic [CH_W-1:0]  ch;
        pick = $urandom_range(99);
        c = CMD_START;
        p = PER_W'($urandom_range(NUM_PERIPHERALS - 1));
        t = TAG_W'($urandom_range(255));
        ch = CH_W'($urandom_range(NUM_CHANNELS - 1));
        if (pick < 4)
        begin
            p = PER_W'($urandom_range(31, NUM_PERIPHERALS));
        end
        else if (pick < 7)
        begin
            c = CMD_UNUSED;
        end
        else if (pick < (fill_mode ? 72 : 37))
        begin
            c = CMD_START;
        end
        else if (pick < (fill_mode ? 87 : 82))
        begin
            c = CMD_DONE;
        end
        else
        begin
            c = CMD_ABORT;
            if ($urandom_range(3) != 0)
            begin
                void'(tracker.pick_queued_tag(ch, t));
            end
        end
        send_req(c, p, t, ch);
    endtask

    initial
    begin
        tracker = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Done on an idle channel, abort on an empty queue, the unused command
        // and peripheral ids out of range.
        send_req(CMD_DONE, 5'd0, 8'd0, 2'd0);
        send_req(CMD_ABORT, 5'd0, 8'd0, 2'd3);
        send_req(CMD_UNUSED, 5'd31, 8'd255, 2'd2);
        send_req(CMD_START, 5'd20, 8'd17, 2'd0);
        send_req(CMD_START, 5'd31, 8'd255, 2'd3);
        // A software request, then a request that must wait behind it.
        send_req(CMD_START, 5'd0, 8'd0, 2'd0);
        send_req(CMD_START, 5'd1, 8'd255, 2'd0);
        // Walk a three-channel preference list and queue once all are busy.
        send_req(CMD_START, 5'd8, 8'h11, 2'd0);
        send_req(CMD_START, 5'd8, 8'h22, 2'd0);
        send_req(CMD_START, 5'd8, 8'h33, 2'd0);
        send_req(CMD_START, 5'd8, 8'h5a, 2'd0);
        send_req(CMD_ABORT, 5'd0, 8'h5a, 2'd3);
        // Aborting a tag that is only running must miss.
        send_req(CMD_ABORT, 5'd0, 8'h33, 2'd1);
        send_req(CMD_DONE, 5'd0, 8'd0, 2'd0);
        for (int i = 0; i < QDEPTH + 1; i++)
        begin
            send_req(CMD_START, 5'd19, 8'(8'h80 + i), 2'd0);
        end
        send_req(CMD_DONE, 5'd0, 8'd0, 2'd3);
        send_req(CMD_DONE, 5'd0, 8'd0, 2'd2);

        for (int i = 0; i < ITEMS; i++)
        begin
            if (i == ITEMS / 3)
            begin
                send_idle_pct = 49;
                recv_idle_pct = 19;
            end
            if (i == 2 * ITEMS / 3)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (i % 60 == 0)
            begin
                fill_mode = 1'($urandom_range(1));
            end
            send_random();
        end
        in_valid <= 1'b0;

        while (tracker.pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Drove %0d requests through three idling phases; checked %0d results.",
                 sent, tracker.checked);
        $display("Started %0d, queued %0d, bad id %0d, full %0d, idle %0d, aborted %0d, miss %0d.",
                 tracker.outcome_seen[OC_STARTED], tracker.outcome_seen[OC_QUEUED],
                 tracker.outcome_seen[OC_BADPER], tracker.outcome_seen[OC_FULL],
                 tracker.outcome_seen[OC_IDLE], tracker.outcome_seen[OC_ABORTED],
                 tracker.outcome_seen[OC_MISS]);
        if (tracker.errors == 0 && tracker.pending_results.size() == 0)
        begin
            $display("testbench passed");
        end
        else
        begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/core/dcd_pkg.sv
rtl/core/dcd_ram.sv
rtl/core/dma_channel_dispatcher.sv
tb/sv/dispatch_tb_pkg.sv
tb/sv/testbench.sv
